@@ design/e2r_pkg.sv @@
// Package for the Euler angle to rotation matrix block.
// Holds fixed-point constants, the arctangent table and shared types; no dependencies.
`default_nettype none
package e2r_pkg;

  localparam int AngW = 16;
  localparam int ZW = 34;
  localparam int XW = 34;
  localparam int QW = 16;

  localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] TwoPiQ30 = 34'sd6746518852;
  localparam logic signed [XW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [QW-1:0] OneQ14 = 16'sd16384;
  localparam int AtanEntries = 24;

  typedef logic signed [AngW-1:0] angle_t;
  typedef logic signed [QW-1:0] q14_t;

  typedef struct packed {
    angle_t roll_angle;
    angle_t pitch_angle;
    angle_t yaw_angle;
  } attitude_t;

  typedef struct packed {
    q14_t m00;
    q14_t m01;
    q14_t m02;
    q14_t m10;
    q14_t m11;
    q14_t m12;
    q14_t m20;
    q14_t m21;
    q14_t m22;
  } matrix_t;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic neg;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0: v = 34'sh3243F6A8;
      5'd1: v = 34'sh1DAC6705;
      5'd2: v = 34'sh0FADBAFC;
      5'd3: v = 34'sh07F56EA6;
      5'd4: v = 34'sh03FEAB76;
      5'd5: v = 34'sh01FFD55B;
      5'd6: v = 34'sh00FFFAAA;
      5'd7: v = 34'sh007FFF55;
      5'd8: v = 34'sh003FFFEA;
      5'd9: v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic q14_t clamp_one(input logic signed [47:0] v);
    q14_t r;
    if (v > 48'sd16384) begin
      r = OneQ14;
    end else if (v < -48'sd16384) begin
      r = -OneQ14;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/e2r_if.sv @@
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface e2r_if #(
  parameter type payload_t = logic
) (
  input wire logic clk
);
  logic valid;
  logic ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/e2r_sincos.sv @@
// Pipelined range reduction and CORDIC for one angle, one stage per micro-rotation.
// Depends on e2r_pkg.
`default_nettype none
module e2r_sincos
  import e2r_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input wire logic clk,
  input wire logic en,
  input wire angle_t angle,
  output q14_t sin_q,
  output q14_t cos_q
);
  localparam int NStg = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;

  logic signed [ZW-1:0] zw_r;
  cordic_t st_r [NStg+1];
  q14_t sin_r, cos_r;

  logic signed [ZW-1:0] z0, z1, z2;
  cordic_t st0_nxt;

  always_comb begin
    z0 = {angle, 18'd0};
    z1 = z0;
    if (z0 > PiQ30) begin
      z1 = z0 - TwoPiQ30;
    end else if (z0 < -PiQ30) begin
      z1 = z0 + TwoPiQ30;
    end
    z2 = z1;
    if (z1 > PiQ30) begin
      z2 = z1 - TwoPiQ30;
    end else if (z1 < -PiQ30) begin
      z2 = z1 + TwoPiQ30;
    end
  end

  always_comb begin
    st0_nxt.x = GainQ30;
    st0_nxt.y = '0;
    st0_nxt.z = zw_r;
    st0_nxt.neg = 1'b0;
    if (zw_r > HalfPiQ30) begin
      st0_nxt.z = zw_r - PiQ30;
      st0_nxt.neg = 1'b1;
    end else if (zw_r < -HalfPiQ30) begin
      st0_nxt.z = zw_r + PiQ30;
      st0_nxt.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zw_r <= z2;
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar i = 0; i < NStg; i++) begin : g_stage
    cordic_t s_nxt;
    always_comb begin
      s_nxt.neg = st_r[i].neg;
      if (!st_r[i].z[ZW-1]) begin
        s_nxt.x = st_r[i].x - (st_r[i].y >>> i);
        s_nxt.y = st_r[i].y + (st_r[i].x >>> i);
        s_nxt.z = st_r[i].z - atan_q30(5'(i));
      end else begin
        s_nxt.x = st_r[i].x + (st_r[i].y >>> i);
        s_nxt.y = st_r[i].y - (st_r[i].x >>> i);
        s_nxt.z = st_r[i].z + atan_q30(5'(i));
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i+1] <= s_nxt;
      end
    end
  end

  logic signed [XW-1:0] xr, yr;
  logic signed [47:0] xq, yq;
  always_comb begin
    xr = (st_r[NStg].x + 34'sd32768) >>> 16;
    yr = (st_r[NStg].y + 34'sd32768) >>> 16;
    xq = 48'(xr);
    yq = 48'(yr);
    if (st_r[NStg].neg) begin
      xq = -xq;
      yq = -yq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= clamp_one(xq);
      sin_r <= clamp_one(yq);
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;
endmodule
`default_nettype wire

@@ design/e2r_matrix.sv @@
// Product pipeline that forms the nine rotation matrix entries from sines and cosines.
// Depends on e2r_pkg.
`default_nettype none
module e2r_matrix
  import e2r_pkg::*;
(
  input wire logic clk,
  input wire logic en,
  input wire q14_t sr,
  input wire q14_t cr,
  input wire q14_t sp,
  input wire q14_t cp,
  input wire q14_t sy,
  input wire q14_t cy,
  output q14_t m [9]
);
  // Stage 1: two-factor products in Q28.
  logic signed [31:0] cycp_r, sycp_r, cpsr_r, cpcr_r, cysp_r, sysp_r;
  logic signed [31:0] sycr_r, sysr_r, cycr_r, cysr_r;
  q14_t sr_r, cr_r, sp_r;
  // Stage 2: three-factor products in Q42, two-factor rounded.
  logic signed [47:0] t01_r, t02_r, t11_r, t12_r;
  logic signed [47:0] u01_r, u02_r, u11_r, u12_r;
  q14_t m00_r, m10_r, m20_r, m21_r, m22_r;
  q14_t o_r [9];

  function automatic q14_t rnd2(input logic signed [31:0] p);
    logic signed [31:0] v;
    v = (p + 32'sd8192) >>> 14;
    return clamp_one(48'(v));
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cycp_r <= cy * cp;
      sycp_r <= sy * cp;
      cpsr_r <= cp * sr;
      cpcr_r <= cp * cr;
      cysp_r <= cy * sp;
      sysp_r <= sy * sp;
      sycr_r <= sy * cr;
      sysr_r <= sy * sr;
      cycr_r <= cy * cr;
      cysr_r <= cy * sr;
      sr_r <= sr;
      cr_r <= cr;
      sp_r <= sp;

      t01_r <= 48'(cysp_r) * 48'(sr_r);
      t02_r <= 48'(cysp_r) * 48'(cr_r);
      t11_r <= 48'(sysp_r) * 48'(sr_r);
      t12_r <= 48'(sysp_r) * 48'(cr_r);
      u01_r <= 48'(sycr_r) <<< 14;
      u02_r <= 48'(sysr_r) <<< 14;
      u11_r <= 48'(cycr_r) <<< 14;
      u12_r <= 48'(cysr_r) <<< 14;
      m00_r <= rnd2(cycp_r);
      m10_r <= rnd2(sycp_r);
      m21_r <= rnd2(cpsr_r);
      m22_r <= rnd2(cpcr_r);
      m20_r <= clamp_one(-48'(sp_r));

      o_r[0] <= m00_r;
      o_r[1] <= clamp_one((t01_r - u01_r + 48'sd134217728) >>> 28);
      o_r[2] <= clamp_one((t02_r + u02_r + 48'sd134217728) >>> 28);
      o_r[3] <= m10_r;
      o_r[4] <= clamp_one((t11_r + u11_r + 48'sd134217728) >>> 28);
      o_r[5] <= clamp_one((t12_r - u12_r + 48'sd134217728) >>> 28);
      o_r[6] <= m20_r;
      o_r[7] <= m21_r;
      o_r[8] <= m22_r;
    end
  end

  assign m = o_r;
endmodule
`default_nettype wire

@@ design/euler_to_rotation_matrix.sv @@
// Throughput: one transaction per cycle while the output is not stalled; the pipeline
// advances as one unit on a single shared enable.
// Output stall freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears the valid bits only; data registers are not reset.
`default_nettype none
module euler_to_rotation_matrix
  import e2r_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  e2r_if.sink in_ch,
  e2r_if.source out_ch
);
  localparam int NStg = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int Lat = NStg + 6;

  logic [Lat-1:0] vld_r, vld_nxt;
  logic en;
  q14_t sr, cr, sp, cp, sy, cy;
  q14_t m [9];

  assign en = !vld_r[Lat-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    vld_nxt = vld_r;
    if (en) begin
      vld_nxt = {vld_r[Lat-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  e2r_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .angle(in_ch.data.roll_angle), .sin_q(sr), .cos_q(cr));
  e2r_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .angle(in_ch.data.pitch_angle), .sin_q(sp), .cos_q(cp));
  e2r_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .angle(in_ch.data.yaw_angle), .sin_q(sy), .cos_q(cy));

  e2r_matrix u_mat (
    .clk(clk), .en(en), .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .m(m));

  assign out_ch.valid = vld_r[Lat-1];
  assign out_ch.data.m00 = m[0];
  assign out_ch.data.m01 = m[1];
  assign out_ch.data.m02 = m[2];
  assign out_ch.data.m10 = m[3];
  assign out_ch.data.m11 = m[4];
  assign out_ch.data.m12 = m[5];
  assign out_ch.data.m20 = m[6];
  assign out_ch.data.m21 = m[7];
  assign out_ch.data.m22 = m[8];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed during stall");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_m20_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.m20 <= OneQ14 && out_ch.data.m20 >= -OneQ14))
    else $error("entry out of range");
endmodule
`default_nettype wire
